>>> rtl/pcmq_pkg.sv
// ----------------------------------------------------------------------------
// pcmq_pkg
// Shared types, widths and codes for the three-class priority multi-queue.
// ----------------------------------------------------------------------------
package pcmq_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_CLASSES = 3;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int QID_W       = 2;

  // Field widths
  localparam int SIZE_W    = 16;
  localparam int TAG_W     = 32;
  localparam int PRIO_W    = 4;
  localparam int ENTRIES_W = 6;
  localparam int TSIZE_W   = 22;
  localparam int LIMIT_W   = 4;

  // Reset values of the class limits
  localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST = LIMIT_W'(4);
  localparam logic [LIMIT_W-1:0] MID_LIMIT_RST = LIMIT_W'(7);

  // Queue indexes
  localparam logic [QID_W-1:0] QID_LOW     = QID_W'(0);
  localparam logic [QID_W-1:0] QID_MID     = QID_W'(1);
  localparam logic [QID_W-1:0] QID_HIGH    = QID_W'(2);
  localparam logic [QID_W-1:0] QID_INVALID = QID_W'(3);

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_t;

  typedef enum logic {
    CFG_LOW_LIMIT = 1'b0,
    CFG_MID_LIMIT = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_BAD_QUEUE = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_POP  = 1'b1
  } state_t;

  // One stored entry
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Decision for the transaction presented at the input
  typedef struct packed {
    logic              push;
    logic              pop;
    status_t           status;
    logic [ADDR_W-1:0] addr;
  } op_dec_t;

endpackage

>>> rtl/pcmq_entry_ram.sv
// ----------------------------------------------------------------------------
// pcmq_entry_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pcmq_entry_ram #(
  parameter  int DATA_W = 8,
  parameter  int DEPTH  = 16,
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/pcmq_queue_state.sv
// ----------------------------------------------------------------------------
// pcmq_queue_state
// Class limits, per-queue head/tail pointers and fill counts; decides each
// transaction and advances the pointers when it commits.
// ----------------------------------------------------------------------------
module pcmq_queue_state (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_index,
  input  logic [pcmq_pkg::LIMIT_W-1:0]    cfg_wr_data,
  input  logic                            func,
  input  logic [pcmq_pkg::PRIO_W-1:0]     prio,
  input  logic [pcmq_pkg::QID_W-1:0]      queue_sel,
  input  logic                            commit,
  output pcmq_pkg::op_dec_t               dec
);

  localparam logic [pcmq_pkg::PTR_W-1:0] PTR_LAST =
    pcmq_pkg::PTR_W'(pcmq_pkg::QUEUE_DEPTH - 1);
  localparam logic [pcmq_pkg::CNT_W-1:0] CNT_FULL =
    pcmq_pkg::CNT_W'(pcmq_pkg::QUEUE_DEPTH);
  localparam logic [pcmq_pkg::ADDR_W-1:0] Q_STRIDE =
    pcmq_pkg::ADDR_W'(pcmq_pkg::QUEUE_DEPTH);

  logic [pcmq_pkg::LIMIT_W-1:0] low_limit_r, mid_limit_r;
  logic [pcmq_pkg::PTR_W-1:0]   head_r [pcmq_pkg::NUM_CLASSES];
  logic [pcmq_pkg::PTR_W-1:0]   tail_r [pcmq_pkg::NUM_CLASSES];
  logic [pcmq_pkg::CNT_W-1:0]   cnt_r  [pcmq_pkg::NUM_CLASSES];
  logic [pcmq_pkg::PTR_W-1:0]   head_nxt [pcmq_pkg::NUM_CLASSES];
  logic [pcmq_pkg::PTR_W-1:0]   tail_nxt [pcmq_pkg::NUM_CLASSES];
  logic [pcmq_pkg::CNT_W-1:0]   cnt_nxt  [pcmq_pkg::NUM_CLASSES];

  logic [pcmq_pkg::QID_W-1:0]   q_ins;
  logic [pcmq_pkg::QID_W-1:0]   q_op;
  logic [pcmq_pkg::PTR_W-1:0]   ptr_sel;
  logic [pcmq_pkg::PTR_W-1:0]   ptr_adv;
  logic [pcmq_pkg::CNT_W-1:0]   cnt_sel;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_limit_r <= pcmq_pkg::LOW_LIMIT_RST;
      mid_limit_r <= pcmq_pkg::MID_LIMIT_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == pcmq_pkg::CFG_LOW_LIMIT) begin
        low_limit_r <= cfg_wr_data;
      end else begin
        mid_limit_r <= cfg_wr_data;
      end
    end
  end

  // Class select, limits compared in order
  always_comb begin
    if (prio < low_limit_r) begin
      q_ins = pcmq_pkg::QID_LOW;
    end else if (prio < mid_limit_r) begin
      q_ins = pcmq_pkg::QID_MID;
    end else begin
      q_ins = pcmq_pkg::QID_HIGH;
    end
  end

  // Decision
  always_comb begin
    q_op    = (func == pcmq_pkg::FUNC_INSERT) ? q_ins : queue_sel;
    cnt_sel = '0;
    ptr_sel = '0;
    if (q_op != pcmq_pkg::QID_INVALID) begin
      cnt_sel = cnt_r[q_op];
      ptr_sel = (func == pcmq_pkg::FUNC_INSERT) ? tail_r[q_op] : head_r[q_op];
    end
    ptr_adv = (ptr_sel == PTR_LAST) ? '0 : ptr_sel + pcmq_pkg::PTR_W'(1);

    dec.push   = 1'b0;
    dec.pop    = 1'b0;
    dec.status = pcmq_pkg::STAT_OK;
    dec.addr   = pcmq_pkg::ADDR_W'(q_op) * Q_STRIDE + pcmq_pkg::ADDR_W'(ptr_sel);
    if (func == pcmq_pkg::FUNC_INSERT) begin
      if (cnt_sel == CNT_FULL) begin
        dec.status = pcmq_pkg::STAT_FULL;
      end else begin
        dec.push = 1'b1;
      end
    end else if (queue_sel == pcmq_pkg::QID_INVALID) begin
      dec.status = pcmq_pkg::STAT_BAD_QUEUE;
    end else if (cnt_sel == '0) begin
      dec.status = pcmq_pkg::STAT_EMPTY;
    end else begin
      dec.pop = 1'b1;
    end
  end

  // Pointer and count update on commit
  always_comb begin
    for (int i = 0; i < pcmq_pkg::NUM_CLASSES; i++) begin
      head_nxt[i] = head_r[i];
      tail_nxt[i] = tail_r[i];
      cnt_nxt[i]  = cnt_r[i];
    end
    if (commit && dec.push) begin
      tail_nxt[q_op] = ptr_adv;
      cnt_nxt[q_op]  = cnt_sel + pcmq_pkg::CNT_W'(1);
    end else if (commit && dec.pop) begin
      head_nxt[q_op] = ptr_adv;
      cnt_nxt[q_op]  = cnt_sel - pcmq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pcmq_pkg::NUM_CLASSES; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < pcmq_pkg::NUM_CLASSES; i++) begin
        head_r[i] <= head_nxt[i];
        tail_r[i] <= tail_nxt[i];
        cnt_r[i]  <= cnt_nxt[i];
      end
    end
  end

endmodule

>>> rtl/priority_class_multi_queue.sv
// ----------------------------------------------------------------------------
// priority_class_multi_queue
// Three FIFO queues sharing one entry RAM; inserts pick a queue by priority
// class, removes pop the head of a selected queue. Every transaction yields
// one result with status, popped entry and running totals.
// ----------------------------------------------------------------------------
// Timing: inserts and failed operations load the output register at the
//   accept edge; a successful remove reads the RAM, then loads it in S_POP.
// Throughput: one transaction per cycle, less when the single output register
//   stalls or a successful remove waits in S_POP on the registered RAM read.
// Reset: synchronous, active low; clears pointers, counts, totals and output
//   valid, limits back to 4 and 7; the entry RAM is not cleared.
module priority_class_multi_queue (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_wr_en,
  input  logic                             cfg_index,
  input  logic [pcmq_pkg::LIMIT_W-1:0]     cfg_wr_data,
  // input transactions
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_func,
  input  logic [pcmq_pkg::SIZE_W-1:0]      in_entry_size,
  input  logic [pcmq_pkg::TAG_W-1:0]       in_entry_tag,
  input  logic [pcmq_pkg::PRIO_W-1:0]      in_entry_priority,
  input  logic [pcmq_pkg::QID_W-1:0]       in_queue_select,
  // result transactions
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_status,
  output logic [pcmq_pkg::SIZE_W-1:0]      out_popped_size,
  output logic [pcmq_pkg::TAG_W-1:0]       out_popped_tag,
  output logic [pcmq_pkg::PRIO_W-1:0]      out_popped_priority,
  output logic [pcmq_pkg::ENTRIES_W-1:0]   out_total_entries,
  output logic [pcmq_pkg::TSIZE_W-1:0]     out_total_size
);

  pcmq_pkg::state_t  state_r, state_nxt;
  pcmq_pkg::op_dec_t dec;
  pcmq_pkg::entry_t  wr_entry, rd_entry;
  logic [pcmq_pkg::ENTRY_W-1:0] rd_word;
  logic              accept;

  // Running totals (wrap at field width)
  logic [pcmq_pkg::ENTRIES_W-1:0] entries_r, entries_nxt;
  logic [pcmq_pkg::TSIZE_W-1:0]   tsize_r, tsize_nxt;

  // Output register
  logic                           out_valid_r, out_valid_nxt;
  pcmq_pkg::status_t              status_r, status_nxt;
  logic [pcmq_pkg::SIZE_W-1:0]    psize_r, psize_nxt;
  logic [pcmq_pkg::TAG_W-1:0]     ptag_r, ptag_nxt;
  logic [pcmq_pkg::PRIO_W-1:0]    pprio_r, pprio_nxt;

  // Take a new transaction when idle and the output register is free or is
  // being drained this cycle. A pending pop always finds the register free
  // in S_POP since only this block loads it.
  assign in_ready = (state_r == pcmq_pkg::S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // Queue bookkeeping and per-transaction decision
  pcmq_queue_state u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .func        (in_func),
    .prio        (in_entry_priority),
    .queue_sel   (in_queue_select),
    .commit      (accept),
    .dec         (dec)
  );

  assign wr_entry.size = in_entry_size;
  assign wr_entry.tag  = in_entry_tag;
  assign wr_entry.prio = in_entry_priority;

  // Entry store: insert writes at the tail, remove reads at the head. Only
  // one access happens per accepted transaction, so no forwarding is needed;
  // a later write can only land after the read data is captured.
  pcmq_entry_ram #(
    .DATA_W (pcmq_pkg::ENTRY_W),
    .DEPTH  (pcmq_pkg::STORE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (accept && dec.push),
    .wr_addr (dec.addr),
    .wr_data (wr_entry),
    .rd_en   (accept && dec.pop),
    .rd_addr (dec.addr),
    .rd_data (rd_word)
  );

  assign rd_entry = pcmq_pkg::entry_t'(rd_word);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pcmq_pkg::S_IDLE: begin
        if (accept && dec.pop) begin
          state_nxt = pcmq_pkg::S_POP;
        end
      end
      pcmq_pkg::S_POP: begin
        state_nxt = pcmq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = pcmq_pkg::S_IDLE;
      end
    endcase
  end

  // Result and totals
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    psize_nxt     = psize_r;
    ptag_nxt      = ptag_r;
    pprio_nxt     = pprio_r;
    entries_nxt   = entries_r;
    tsize_nxt     = tsize_r;
    case (state_r)
      pcmq_pkg::S_POP: begin
        // RAM data for the popped head is valid now
        out_valid_nxt = 1'b1;
        status_nxt    = pcmq_pkg::STAT_OK;
        psize_nxt     = rd_entry.size;
        ptag_nxt      = rd_entry.tag;
        pprio_nxt     = rd_entry.prio;
        entries_nxt   = entries_r - pcmq_pkg::ENTRIES_W'(1);
        tsize_nxt     = tsize_r - pcmq_pkg::TSIZE_W'(rd_entry.size);
      end
      pcmq_pkg::S_IDLE: begin
        if (accept && !dec.pop) begin
          out_valid_nxt = 1'b1;
          status_nxt    = dec.status;
          psize_nxt     = '0;
          ptag_nxt      = '0;
          pprio_nxt     = '0;
          if (dec.push) begin
            entries_nxt = entries_r + pcmq_pkg::ENTRIES_W'(1);
            tsize_nxt   = tsize_r + pcmq_pkg::TSIZE_W'(in_entry_size);
          end
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && !out_ready;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcmq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      entries_r   <= '0;
      tsize_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      entries_r   <= entries_nxt;
      tsize_r     <= tsize_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    psize_r  <= psize_nxt;
    ptag_r   <= ptag_nxt;
    pprio_r  <= pprio_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_popped_size     = psize_r;
  assign out_popped_tag      = ptag_r;
  assign out_popped_priority = pprio_r;
  assign out_total_entries   = entries_r;
  assign out_total_size      = tsize_r;

endmodule
